// ----- hdl/spss_pkg.sv -----
package spss_pkg;

  localparam int MAX_MOVES  = 64;
  localparam int NUM_SERVOS = 5;
  localparam int DUTY_BITS  = 14;

  localparam int ROW_BITS   = (MAX_MOVES > 1) ? $clog2(MAX_MOVES) : 1;
  localparam int IDX_BITS   = 6;
  localparam int MC_BITS    = 7;
  localparam int SERVO_BITS = 3;
  localparam int CFG_BITS   = 3;
  localparam int CMP_BITS   = DUTY_BITS + 3;

  localparam int LEVER_SERVO = 2;
  localparam int GRIP_SERVO  = 4;

  localparam logic [DUTY_BITS-1:0] RESET_DUTY    = DUTY_BITS'(937);
  localparam logic [DUTY_BITS-1:0] RESET_GRIPMAX = DUTY_BITS'(1562);
  localparam logic [DUTY_BITS-1:0] RESET_GRIPMIN = DUTY_BITS'(312);
  localparam logic [MC_BITS-1:0]   RESET_MOVES   = MC_BITS'(1);

  localparam logic signed [CMP_BITS-1:0] MANUAL_STEP = CMP_BITS'(10);
  localparam logic signed [CMP_BITS-1:0] SLEW_STEP   = CMP_BITS'(5);

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_HOME  = 2'd2,
    MODE_PLAY  = 2'd3
  } mode_t;

  typedef enum logic [CFG_BITS-1:0] {
    CFG_HOME0      = 3'd0,
    CFG_HOME1      = 3'd1,
    CFG_HOME2      = 3'd2,
    CFG_HOME3      = 3'd3,
    CFG_HOME4      = 3'd4,
    CFG_GRIP_MAX   = 3'd5,
    CFG_GRIP_MIN   = 3'd6,
    CFG_MOVE_COUNT = 3'd7
  } cfg_idx_t;

  typedef logic [NUM_SERVOS-1:0][DUTY_BITS-1:0] duty_arr_t;

  typedef struct packed {
    mode_t                 mode;
    logic [DUTY_BITS-1:0]  lever_target;
    logic                  manual_enable;
    logic                  open_button;
    logic                  close_button;
    logic                  recorded;
    logic [IDX_BITS-1:0]   entry_row;
    logic [SERVO_BITS-1:0] entry_servo;
    logic [DUTY_BITS-1:0]  entry_value;
  } in_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] duty_0;
    logic [DUTY_BITS-1:0] duty_1;
    logic [DUTY_BITS-1:0] duty_2;
    logic [DUTY_BITS-1:0] duty_3;
    logic [DUTY_BITS-1:0] duty_4;
    logic                 homing_active;
    logic                 playback_active;
    logic [IDX_BITS-1:0]  current_row;
  } out_t;

  typedef struct packed {
    duty_arr_t            home_pos;
    logic [DUTY_BITS-1:0] grip_max;
    logic [DUTY_BITS-1:0] grip_min;
    logic [MC_BITS-1:0]   move_count;
  } cfg_t;

  typedef struct packed {
    logic                  en;
    logic [NUM_SERVOS-1:0] col_en;
    logic [ROW_BITS-1:0]   addr;
    logic [DUTY_BITS-1:0]  data;
  } seq_wr_t;

endpackage

// ----- hdl/servo_position_slew_sequencer_top.sv -----
// Every item, tick or command, gives one result, registered in the output queue.
// Throughput: one transaction per cycle while in_stall is low.
// A two-slot output queue lets input run on while one result waits; stall rises only
// when both slots hold unsent results. The sequence row is read ahead, at the next row index.
// Reset (synchronous, rst high): pulse widths 937, flags and row index clear, registers
// to defaults; the sequence memory is not cleared and holds no valid bits.
module servo_position_slew_sequencer_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  spss_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output spss_pkg::out_t                    out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [spss_pkg::CFG_BITS-1:0]     cfg_index,
  input  logic [spss_pkg::DUTY_BITS-1:0]    cfg_data
);
  import spss_pkg::*;

  // A transaction on the input side is taken whenever the output queue has a free slot.
  logic      accept;
  cfg_t      cfg;
  seq_wr_t   seq_wr;
  logic [ROW_BITS-1:0] seq_rd_addr;
  duty_arr_t seq_row;
  out_t      result;

  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers. The user must send writes only while the block is idle, so
  // the datapath sees a steady value during every tick; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_SERVOS; c++) begin
        cfg.home_pos[c] <= RESET_DUTY;
      end
      cfg.grip_max   <= RESET_GRIPMAX;
      cfg.grip_min   <= RESET_GRIPMIN;
      cfg.move_count <= RESET_MOVES;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HOME0:      cfg.home_pos[0] <= cfg_data;
        CFG_HOME1:      cfg.home_pos[1] <= cfg_data;
        CFG_HOME2:      cfg.home_pos[2] <= cfg_data;
        CFG_HOME3:      cfg.home_pos[3] <= cfg_data;
        CFG_HOME4:      cfg.home_pos[4] <= cfg_data;
        CFG_GRIP_MAX:   cfg.grip_max    <= cfg_data;
        CFG_GRIP_MIN:   cfg.grip_min    <= cfg_data;
        CFG_MOVE_COUNT: cfg.move_count  <= cfg_data[MC_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequence memory: one row per recorded move, all servo columns side by side,
  // so a playback tick finds its whole target row in the read register.
  spss_seq_ram u_ram (
    .clk     (clk),
    .wr      (seq_wr),
    .rd_addr (seq_rd_addr),
    .rd_data (seq_row)
  );

  // Servo state and the per-tick manual, gripper, homing and playback steps.
  spss_slew_core u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (in_data),
    .cfg      (cfg),
    .row_data (seq_row),
    .wr       (seq_wr),
    .rd_addr  (seq_rd_addr),
    .result   (result)
  );

  // Output register with a skid slot behind it.
  spss_out_q u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- hdl/spss_seq_ram.sv -----
module spss_seq_ram (
  input  logic                clk,
  input  spss_pkg::seq_wr_t   wr,
  input  logic [spss_pkg::ROW_BITS-1:0] rd_addr,
  output spss_pkg::duty_arr_t rd_data
);
  import spss_pkg::*;

  // One row holds all servo columns; writes go to a single column.
  duty_arr_t mem [MAX_MOVES];

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_SERVOS; c++) begin
      if (wr.en && wr.col_en[c]) begin
        mem[wr.addr][c] <= wr.data;
      end
    end
  end

  // Registered read with write-first bypass for a column written this cycle.
  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_SERVOS; c++) begin
      if (wr.en && wr.col_en[c] && (wr.addr == rd_addr)) begin
        rd_data[c] <= wr.data;
      end else begin
        rd_data[c] <= mem[rd_addr][c];
      end
    end
  end

endmodule

// ----- hdl/spss_slew_core.sv -----
module spss_slew_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  spss_pkg::in_t       item,
  input  spss_pkg::cfg_t      cfg,
  input  spss_pkg::duty_arr_t row_data,
  output spss_pkg::seq_wr_t   wr,
  output logic [spss_pkg::ROW_BITS-1:0] rd_addr,
  output spss_pkg::out_t      result
);
  import spss_pkg::*;

  typedef struct packed {
    logic [DUTY_BITS-1:0] duty;
    logic                 hit;
  } slew_t;

  function automatic logic signed [CMP_BITS-1:0] wide(input logic [DUTY_BITS-1:0] v);
    return signed'(CMP_BITS'(v));
  endfunction

  function automatic slew_t slew_step(input logic [DUTY_BITS-1:0] d,
                                      input logic [DUTY_BITS-1:0] t);
    slew_t r;
    r.hit = 1'b0;
    if (wide(d) + SLEW_STEP < wide(t)) begin
      r.duty = DUTY_BITS'(wide(d) + SLEW_STEP);
    end else if (wide(d) - SLEW_STEP > wide(t)) begin
      r.duty = DUTY_BITS'(wide(d) - SLEW_STEP);
    end else begin
      r.duty = t;
      r.hit  = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [DUTY_BITS-1:0] lever_step(input logic [DUTY_BITS-1:0] d,
                                                      input logic [DUTY_BITS-1:0] t);
    logic [DUTY_BITS-1:0] r;
    r = d;
    if (wide(d) < wide(t)) begin
      r = (wide(d) + MANUAL_STEP >= wide(t)) ? t : DUTY_BITS'(wide(d) + MANUAL_STEP);
    end else if (wide(d) > wide(t)) begin
      r = (wide(d) - MANUAL_STEP <= wide(t)) ? t : DUTY_BITS'(wide(d) - MANUAL_STEP);
    end
    return r;
  endfunction

  duty_arr_t             duty;
  duty_arr_t             duty_next;
  duty_arr_t             target;
  logic [NUM_SERVOS-1:0] reached;
  logic [NUM_SERVOS-1:0] reached_next;
  logic                  homing;
  logic                  homing_next;
  logic                  playing;
  logic                  playing_next;
  logic [IDX_BITS-1:0]   move_index;
  logic [IDX_BITS-1:0]   move_index_next;
  logic [MC_BITS-1:0]    row_inc;
  slew_t                 home_s [NUM_SERVOS];
  slew_t                 play_s [NUM_SERVOS];

  always_comb begin
    for (int c = 0; c < NUM_SERVOS; c++) begin
      target[c] = (int'(move_index) < MAX_MOVES) ? row_data[c] : '0;
    end
  end

  assign row_inc = MC_BITS'({1'b0, move_index} + MC_BITS'(1));

  always_comb begin
    duty_next       = duty;
    reached_next    = reached;
    homing_next     = homing;
    playing_next    = playing;
    move_index_next = move_index;
    wr              = '0;
    wr.addr         = ROW_BITS'(item.entry_row);
    wr.data         = item.entry_value;
    for (int c = 0; c < NUM_SERVOS; c++) begin
      wr.col_en[c] = (item.entry_servo == SERVO_BITS'(c));
      home_s[c]    = '0;
      play_s[c]    = '0;
    end
    if (accept) begin
      unique case (item.mode)
        MODE_TICK: begin
          if (item.manual_enable) begin
            duty_next[LEVER_SERVO] = lever_step(duty_next[LEVER_SERVO], item.lever_target);
          end
          if (item.open_button) begin
            duty_next[GRIP_SERVO] =
              (wide(duty_next[GRIP_SERVO]) + MANUAL_STEP < wide(cfg.grip_max)) ?
              DUTY_BITS'(wide(duty_next[GRIP_SERVO]) + MANUAL_STEP) : cfg.grip_max;
          end
          if (item.close_button) begin
            duty_next[GRIP_SERVO] =
              (wide(duty_next[GRIP_SERVO]) - MANUAL_STEP > wide(cfg.grip_min)) ?
              DUTY_BITS'(wide(duty_next[GRIP_SERVO]) - MANUAL_STEP) : cfg.grip_min;
          end
          if (homing_next) begin
            for (int c = 0; c < NUM_SERVOS; c++) begin
              home_s[c]       = slew_step(duty_next[c], cfg.home_pos[c]);
              duty_next[c]    = home_s[c].duty;
              reached_next[c] = reached_next[c] | home_s[c].hit;
            end
            if (&reached_next) begin
              reached_next = '0;
              homing_next  = 1'b0;
            end
          end
          // Playback may start in the same tick in which homing finishes.
          if (playing_next && !homing_next && item.recorded) begin
            for (int c = 0; c < NUM_SERVOS; c++) begin
              play_s[c]       = slew_step(duty_next[c], target[c]);
              duty_next[c]    = play_s[c].duty;
              reached_next[c] = reached_next[c] | play_s[c].hit;
            end
            if (&reached_next) begin
              reached_next = '0;
              if (row_inc == cfg.move_count) begin
                playing_next    = 1'b0;
                move_index_next = '0;
              end else begin
                move_index_next = row_inc[IDX_BITS-1:0];
              end
            end
          end
        end
        MODE_WRITE: begin
          wr.en = (int'(item.entry_servo) < NUM_SERVOS) && (int'(item.entry_row) < MAX_MOVES);
        end
        MODE_HOME: begin
          homing_next = 1'b1;
        end
        MODE_PLAY: begin
          playing_next = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // The read address follows the row that will be current next cycle.
  assign rd_addr = rst ? '0 : ROW_BITS'(move_index_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_SERVOS; c++) begin
        duty[c] <= RESET_DUTY;
      end
      reached    <= '0;
      homing     <= 1'b0;
      playing    <= 1'b0;
      move_index <= '0;
    end else begin
      duty       <= duty_next;
      reached    <= reached_next;
      homing     <= homing_next;
      playing    <= playing_next;
      move_index <= move_index_next;
    end
  end

  always_comb begin
    result.duty_0          = duty_next[0];
    result.duty_1          = duty_next[1];
    result.duty_2          = duty_next[2];
    result.duty_3          = duty_next[3];
    result.duty_4          = duty_next[4];
    result.homing_active   = homing_next;
    result.playback_active = playing_next;
    result.current_row     = move_index_next;
  end

  a_flags_never_full: assert property (@(posedge clk) disable iff (rst) !(&reached))
    else $error("all reached flags left set");
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(duty) && $stable(move_index))
    else $error("state changed without a transaction");
  a_stop_at_row0: assert property (@(posedge clk) disable iff (rst)
    $fell(playing) |-> (move_index == '0))
    else $error("playback stopped away from row zero");

endmodule

// ----- hdl/spss_out_q.sv -----
module spss_out_q (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  spss_pkg::out_t push_data,
  output logic           full,
  output logic           out_valid,
  input  logic           out_stall,
  output spss_pkg::out_t out_data
);
  import spss_pkg::*;

  out_t skid_data;
  logic skid_valid;
  logic pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        out_data  <= push_data;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end else begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end
    end
  end

  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot filled while head slot empty");
  a_held_head: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_stall |=> out_valid && !skid_valid)
    else $error("skid slot did not move to head");

endmodule
